// ===== rtl/bba_pkg.sv =====
// Shared types and constants of the buddy block allocator.
// Depends on nothing; every other file of the allocator imports it.
`default_nettype none

package bba_pkg;

  localparam int REQ_W = 32;
  localparam int OFF_W = 25;
  localparam int NEED_W = REQ_W + 1;

  localparam int MIN_BLOCK_BYTES_DEF = 32;
  localparam int TOP_LEVEL_DEF = 12;
  localparam int HEADER_BYTES_DEF = 32;
  localparam int POOL_CHUNKS_DEF = 256;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_LARGE = 2'd1,
    ST_NO_MEM    = 2'd2
  } status_t;

  typedef struct packed {
    logic             valid;
    status_t          status;
    logic [OFF_W-1:0] offset;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/bba_level_store.sv =====
// Per-level free list: one valid bit and one block offset per level.
// Depends on bba_pkg for the offset width.
`default_nettype none

module bba_level_store
  import bba_pkg::*;
#(
  parameter int NUM_LEVELS = TOP_LEVEL_DEF + 1,
  parameter int LVL_W = $clog2(NUM_LEVELS)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire logic [LVL_W-1:0] wr_idx,
  input  wire logic             wr_valid,
  input  wire logic [OFF_W-1:0] wr_offset,
  input  wire logic [LVL_W-1:0] rd_idx,
  output logic                  rd_valid,
  output logic      [OFF_W-1:0] rd_offset
);

  logic [NUM_LEVELS-1:0] valid_r;
  logic [OFF_W-1:0]      offset_r [NUM_LEVELS];

  // valid bits clear on reset; offsets are only read behind a set valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_idx] <= wr_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      offset_r[wr_idx] <= wr_offset;
    end
  end

  assign rd_valid  = valid_r[rd_idx];
  assign rd_offset = offset_r[rd_idx];

endmodule

`default_nettype wire

// ===== rtl/bba_ctrl.sv =====
// Allocation sequencer: one shared compare/shift unit walks level sizing,
// free-level search and block splitting. Depends on bba_pkg and drives bba_level_store.
`default_nettype none

module bba_ctrl
  import bba_pkg::*;
#(
  parameter int MIN_BLOCK_BYTES = MIN_BLOCK_BYTES_DEF,
  parameter int TOP_LEVEL = TOP_LEVEL_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF,
  parameter int POOL_CHUNKS = POOL_CHUNKS_DEF,
  parameter int LVL_W = $clog2(TOP_LEVEL + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [REQ_W-1:0] req_bytes,
  output logic                  idle,
  output logic                  wr_en,
  output logic      [LVL_W-1:0] wr_idx,
  output logic                  wr_valid,
  output logic      [OFF_W-1:0] wr_offset,
  output logic      [LVL_W-1:0] rd_idx,
  input  wire logic             rd_valid,
  input  wire logic [OFF_W-1:0] rd_offset,
  input  wire logic             res_free,
  output result_t               res
);

  localparam int SPACE_W = $clog2(MIN_BLOCK_BYTES) + TOP_LEVEL + 1;
  localparam int CMP_W = (SPACE_W > NEED_W) ? SPACE_W : NEED_W;
  localparam int WIDE_W = (SPACE_W > OFF_W) ? SPACE_W : OFF_W;
  localparam int CNT_W = $clog2(POOL_CHUNKS + 1);
  localparam logic [SPACE_W-1:0] MIN_SP = SPACE_W'(MIN_BLOCK_BYTES);
  localparam logic [SPACE_W-1:0] CHUNK_SP = MIN_SP << TOP_LEVEL;
  localparam logic [WIDE_W-1:0] CHUNK_WIDE = WIDE_W'(CHUNK_SP);
  localparam logic [OFF_W-1:0] CHUNK_OFF = CHUNK_WIDE[OFF_W-1:0];
  localparam logic [LVL_W-1:0] TOP_IDX = LVL_W'(TOP_LEVEL);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_CHECK  = 6'b000010,
    S_LEVEL  = 6'b000100,
    S_SEARCH = 6'b001000,
    S_SPLIT  = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t              state_r, state_nxt;
  logic [NEED_W-1:0]   need_r, need_nxt;
  logic [SPACE_W-1:0]  space_r, space_nxt;
  logic [LVL_W-1:0]    level_r, level_nxt;
  logic [LVL_W-1:0]    src_r, src_nxt;
  logic [OFF_W-1:0]    base_r, base_nxt;
  logic [CNT_W-1:0]    chunks_r, chunks_nxt;
  logic [OFF_W-1:0]    chunk_base_r, chunk_base_nxt;
  status_t             res_status_r, res_status_nxt;
  logic [OFF_W-1:0]    res_off_r, res_off_nxt;

  logic [SPACE_W-1:0]  cmp_opnd;
  logic                need_gt;
  logic [LVL_W-1:0]    src_m1;
  logic [WIDE_W-1:0]   half_wide;
  logic [OFF_W-1:0]    half_off;
  logic                pool_full;

  // shared compare unit: chunk size during the check, block size while sizing
  assign cmp_opnd = (state_r == S_CHECK) ? CHUNK_SP : space_r;
  assign need_gt = CMP_W'(need_r) > CMP_W'(cmp_opnd);

  // shared shift unit: size of the upper half left free one level down
  assign src_m1 = src_r - LVL_W'(1);
  assign half_wide = WIDE_W'(MIN_SP) << src_m1;
  assign half_off = half_wide[OFF_W-1:0];

  assign pool_full = (chunks_r == CNT_W'(POOL_CHUNKS));
  assign idle = (state_r == S_IDLE);
  assign rd_idx = src_r;

  always_comb begin
    state_nxt = state_r;
    need_nxt = need_r;
    space_nxt = space_r;
    level_nxt = level_r;
    src_nxt = src_r;
    base_nxt = base_r;
    chunks_nxt = chunks_r;
    chunk_base_nxt = chunk_base_r;
    res_status_nxt = res_status_r;
    res_off_nxt = res_off_r;
    wr_en = 1'b0;
    wr_idx = src_r;
    wr_valid = 1'b0;
    wr_offset = rd_offset;
    res.valid = 1'b0;
    res.status = res_status_r;
    res.offset = res_off_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          need_nxt = NEED_W'(req_bytes) + NEED_W'(HEADER_BYTES);
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (need_gt) begin
          res_status_nxt = ST_TOO_LARGE;
          res_off_nxt = '0;
          state_nxt = S_DONE;
        end else begin
          // first request seeds the top level with a fresh chunk
          if (chunks_r == '0) begin
            wr_en = 1'b1;
            wr_idx = TOP_IDX;
            wr_valid = 1'b1;
            wr_offset = chunk_base_r;
            chunks_nxt = chunks_r + CNT_W'(1);
            chunk_base_nxt = chunk_base_r + CHUNK_OFF;
          end
          level_nxt = '0;
          space_nxt = MIN_SP;
          state_nxt = S_LEVEL;
        end
      end
      S_LEVEL: begin
        if (need_gt && (level_r != TOP_IDX)) begin
          space_nxt = space_r << 1;
          level_nxt = level_r + LVL_W'(1);
        end else begin
          src_nxt = level_r;
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (rd_valid) begin
          base_nxt = rd_offset;
          wr_en = 1'b1;
          wr_valid = 1'b0;
          state_nxt = S_SPLIT;
        end else if (src_r == TOP_IDX) begin
          if (pool_full) begin
            res_status_nxt = ST_NO_MEM;
            res_off_nxt = '0;
            state_nxt = S_DONE;
          end else begin
            // new chunk goes straight to splitting, never parked at the top
            base_nxt = chunk_base_r;
            chunks_nxt = chunks_r + CNT_W'(1);
            chunk_base_nxt = chunk_base_r + CHUNK_OFF;
            state_nxt = S_SPLIT;
          end
        end else begin
          src_nxt = src_r + LVL_W'(1);
        end
      end
      S_SPLIT: begin
        if (src_r > level_r) begin
          wr_en = 1'b1;
          wr_idx = src_m1;
          wr_valid = 1'b1;
          wr_offset = base_r + half_off;
          src_nxt = src_m1;
        end else begin
          res_status_nxt = ST_OK;
          res_off_nxt = base_r + OFF_W'(HEADER_BYTES);
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (res_free) begin
          res.valid = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      chunks_r <= '0;
      chunk_base_r <= '0;
    end else begin
      state_r <= state_nxt;
      chunks_r <= chunks_nxt;
      chunk_base_r <= chunk_base_nxt;
    end
  end

  always_ff @(posedge clk) begin
    need_r <= need_nxt;
    space_r <= space_nxt;
    level_r <= level_nxt;
    src_r <= src_nxt;
    base_r <= base_nxt;
    res_status_r <= res_status_nxt;
    res_off_r <= res_off_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/buddy_block_allocator_top.sv =====
// Buddy block allocator, allocation side. out_valid rises from the output register after
// the sequencer finishes: an oversized request stops at the chunk-size check, otherwise the
// sequencer sizes the level, searches the free levels and splits the block, walking one
// level per cycle through the shared compare/shift unit. One transaction at a time: the
// next request is taken once the sequencer is back in idle after handing over its result,
// and a stalled output holds the sequencer. Synchronous active-low reset empties every level.
`default_nettype none

module buddy_block_allocator_top
  import bba_pkg::*;
#(
  parameter int MIN_BLOCK_BYTES = MIN_BLOCK_BYTES_DEF,
  parameter int TOP_LEVEL = TOP_LEVEL_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF,
  parameter int POOL_CHUNKS = POOL_CHUNKS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [REQ_W-1:0] in_request_bytes,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic      [OFF_W-1:0] out_payload_offset,
  output logic      [1:0]       out_status
);

  localparam int NUM_LEVELS = TOP_LEVEL + 1;
  localparam int LVL_W = $clog2(NUM_LEVELS);

  // sequencer <-> level store
  logic             wr_en;
  logic [LVL_W-1:0] wr_idx;
  logic             wr_valid;
  logic [OFF_W-1:0] wr_offset;
  logic [LVL_W-1:0] rd_idx;
  logic             rd_valid;
  logic [OFF_W-1:0] rd_offset;

  logic             ctrl_idle;
  logic             in_take;
  logic             res_free;
  result_t          res;

  // output register parts the result channel from the sequencer
  logic             out_valid_r, out_valid_nxt;
  logic [OFF_W-1:0] out_offset_r;
  status_t          out_status_r;

  // accept a new request only while the sequencer sits idle
  assign in_stall = !ctrl_idle;
  assign in_take = in_valid && ctrl_idle;

  // the sequencer may hand over a result once the output slot is empty or draining
  assign res_free = !out_valid_r || !out_stall;

  bba_ctrl #(
    .MIN_BLOCK_BYTES (MIN_BLOCK_BYTES),
    .TOP_LEVEL       (TOP_LEVEL),
    .HEADER_BYTES    (HEADER_BYTES),
    .POOL_CHUNKS     (POOL_CHUNKS),
    .LVL_W           (LVL_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_take),
    .req_bytes (in_request_bytes),
    .idle      (ctrl_idle),
    .wr_en     (wr_en),
    .wr_idx    (wr_idx),
    .wr_valid  (wr_valid),
    .wr_offset (wr_offset),
    .rd_idx    (rd_idx),
    .rd_valid  (rd_valid),
    .rd_offset (rd_offset),
    .res_free  (res_free),
    .res       (res)
  );

  bba_level_store #(
    .NUM_LEVELS (NUM_LEVELS),
    .LVL_W      (LVL_W)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (wr_en),
    .wr_idx    (wr_idx),
    .wr_valid  (wr_valid),
    .wr_offset (wr_offset),
    .rd_idx    (rd_idx),
    .rd_valid  (rd_valid),
    .rd_offset (rd_offset)
  );

  // hold the transaction while stalled, load a new one when the sequencer finishes
  assign out_valid_nxt = res.valid || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_offset_r <= res.offset;
      out_status_r <= res.status;
    end
  end

  assign out_valid = out_valid_r;
  assign out_payload_offset = out_offset_r;
  assign out_status = out_status_r;

endmodule

`default_nettype wire
